[rtl/lse_pkg.sv]
package lse_pkg;

  localparam int unsigned ByteBits = 8;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_COVER   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } lse_action_t;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_BPB     = 2'd1,
    REG_MSG_LEN = 2'd2,
    REG_NONE    = 2'd3
  } lse_reg_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNDERRUN = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic KIND_COVER   = 1'b0;
  localparam logic KIND_MESSAGE = 1'b1;

  localparam logic MODE_EMBED   = 1'b0;

  // One accepted input word.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] in_value;
    logic       in_last;
  } lse_word_t;

  // Message state carried from word to word.
  typedef struct packed {
    logic [15:0] bit_buffer;
    logic [4:0]  bit_count;
    logic        message_ended;
    logic [15:0] bytes_extracted;
  } lse_state_t;

  // Configuration register set.
  typedef struct packed {
    logic        mode;
    logic [3:0]  bits_per_byte;
    logic [15:0] message_length;
  } lse_cfg_t;

  // One result word.
  typedef struct packed {
    logic [7:0] out_value;
    logic       out_kind;
    logic       out_last;
    logic [1:0] status;
  } lse_result_t;

  // Mask with the low cnt bits set, cnt from 0 to 16.
  function automatic logic [15:0] low_mask16(input logic [4:0] cnt);
    logic [16:0] m;
    m = (17'd1 << cnt) - 17'd1;
    return m[15:0];
  endfunction

  // Reverse the low n bits of v, n from 1 to 8; bits above n must be zero.
  function automatic logic [7:0] rev_n(input logic [7:0] v, input logic [3:0] n);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r >> (4'd8 - n);
  endfunction

endpackage

[rtl/lse_if.sv]
interface lse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] in_value;
  logic       in_last;

  modport source (output valid, output action, output in_value, output in_last,
                  input ready);
  modport sink (input valid, input action, input in_value, input in_last,
                output ready);
endinterface

interface lse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic       out_kind;
  logic       out_last;
  logic [1:0] status;

  modport source (output valid, output out_value, output out_kind,
                  output out_last, output status, input ready);
  modport sink (input valid, input out_value, input out_kind, input out_last,
                input status, output ready);
endinterface

[rtl/lse_step.sv]
// Next-state and result logic for one word: a bit gearbox over a 16-bit buffer.
module lse_step
  import lse_pkg::*;
(
  input  lse_cfg_t    cfg,
  input  lse_state_t  cur,
  input  lse_word_t   word,
  output lse_state_t  nxt,
  output logic        res_valid,
  output lse_result_t res
);

  logic [3:0]  n;
  logic [4:0]  n5;
  logic [7:0]  mask8;
  logic [8:0]  mask9;
  logic [7:0]  chunk;
  logic [4:0]  cnt_new;
  logic [4:0]  cnt_sum;
  logic [15:0] buf_sh;
  logic [15:0] ext_new;
  logic [15:0] rx_sh;

  always_comb begin
    if (cfg.bits_per_byte == 4'd0) begin
      n = 4'd1;
    end else if (cfg.bits_per_byte > 4'd8) begin
      n = 4'd8;
    end else begin
      n = cfg.bits_per_byte;
    end
    n5    = {1'b0, n};
    mask9 = (9'd1 << n) - 9'd1;
    mask8 = mask9[7:0];
  end

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    chunk     = '0;
    cnt_new   = '0;
    cnt_sum   = '0;
    buf_sh    = '0;
    ext_new   = '0;
    rx_sh     = '0;
    case (lse_action_t'(word.action))
      ACT_PUSH: begin
        if (cfg.mode == MODE_EMBED) begin
          if (cur.bit_count > 5'd8 || cur.message_ended) begin
            res_valid  = 1'b1;
            res.status = ST_FULL;
          end else begin
            nxt.bit_buffer = {cur.bit_buffer[7:0], word.in_value};
            nxt.bit_count  = cur.bit_count + 5'd8;
            if (word.in_last) begin
              nxt.message_ended = 1'b1;
            end
          end
        end
      end
      ACT_COVER: begin
        if (cfg.mode == MODE_EMBED) begin
          res_valid = 1'b1;
          if (cur.bit_count == 5'd0 && cur.message_ended) begin
            res.out_value = word.in_value;
          end else begin
            if (cur.bit_count >= n5) begin
              buf_sh  = cur.bit_buffer >> (cur.bit_count - n5);
              chunk   = buf_sh[7:0] & mask8;
              cnt_new = cur.bit_count - n5;
            end else begin
              // Queue runs short: the missing low-order chunk bits are zero.
              buf_sh  = (cur.bit_buffer & low_mask16(cur.bit_count))
                        << (n5 - cur.bit_count);
              chunk   = buf_sh[7:0];
              cnt_new = 5'd0;
              if (!cur.message_ended) begin
                res.status = ST_UNDERRUN;
              end
            end
            nxt.bit_count  = cnt_new;
            nxt.bit_buffer = cur.bit_buffer & low_mask16(cnt_new);
            res.out_last   = cur.message_ended && (cnt_new == 5'd0);
            res.out_value  = (word.in_value & ~mask8) | rev_n(chunk, n);
          end
        end else if (cur.bytes_extracted < cfg.message_length &&
                     cur.bit_count < 5'd8) begin
          buf_sh  = (cur.bit_buffer << n) |
                    {8'h00, rev_n(word.in_value & mask8, n)};
          cnt_sum = cur.bit_count + n5;
          nxt.bit_buffer = buf_sh;
          nxt.bit_count  = cnt_sum;
          if (cnt_sum >= 5'd8) begin
            rx_sh   = buf_sh >> (cnt_sum - 5'd8);
            cnt_new = cnt_sum - 5'd8;
            ext_new = cur.bytes_extracted + 16'd1;
            nxt.bit_count       = cnt_new;
            nxt.bit_buffer      = buf_sh & low_mask16(cnt_new);
            nxt.bytes_extracted = ext_new;
            res_valid     = 1'b1;
            res.out_value = rx_sh[7:0];
            res.out_kind  = KIND_MESSAGE;
            res.out_last  = (ext_new == cfg.message_length);
            if (ext_new == cfg.message_length) begin
              // Leftover bits are dropped with the final message byte.
              nxt.bit_buffer = '0;
              nxt.bit_count  = '0;
            end
          end
        end
      end
      ACT_RESTART: begin
        nxt = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/lsb_stego_embed_extract_top.sv]
// LSB steganography engine, n bits per cover byte. In embed mode (mode 0),
// message bytes pushed with action 0 are queued MSB first, and each cover
// byte (action 1) gets the next n queued bits in its low bits, the first bit
// of the chunk in bit 0. After the byte marked in_last, the final partial
// chunk is padded with zeros and later cover bytes pass unchanged. A push
// is rejected with status 2 while more than 8 bits are queued or after the
// end was marked; a cover byte short of bits before the end reports status 1.
// In extract mode (mode 1), each cover byte yields its n low bits, bit 0
// first, and a message byte word is produced each time 8 bits are gathered,
// until message_length bytes have come out. Action 2 restarts the message
// state, as does any write of the mode register. Throughput is one input
// word per clock with no bubbles while results are taken; a word waits in
// the input register while the bit gearbox works out its result, which is
// then loaded into the result register. The gearbox and its state update
// form a loop closed through the state register alone, which is what lets
// a word follow every cycle. The input register moves forward whenever
// the result register is empty or being drained. While a finished result
// waits, a new word is still taken into an empty input register, but once
// both registers hold a word the input side stalls until the result is
// taken. Configuration must be written only when no word is in flight.
module lsb_stego_embed_extract_top
  import lse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  lse_in_if.sink       in_ch,
  lse_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic        s1_valid;
  lse_word_t   s1_word;
  lse_state_t  state;
  lse_state_t  state_next;
  lse_cfg_t    cfg;
  logic        res_valid;
  lse_result_t res;
  logic        advance;

  // The result register can take a new result when empty or being drained.
  assign advance      = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = !s1_valid || advance;

  lse_step u_step (
    .cfg       (cfg),
    .cur       (state),
    .word      (s1_word),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      out_ch.valid       <= 1'b0;
      state              <= '0;
      cfg.mode           <= MODE_EMBED;
      cfg.bits_per_byte  <= 4'd1;
      cfg.message_length <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance) begin
        out_ch.valid <= s1_valid && res_valid;
      end
      // A write of the mode register restarts the message state.
      if (cfg_we && lse_reg_t'(cfg_index) == REG_MODE) begin
        state <= '0;
      end else if (advance && s1_valid) begin
        state <= state_next;
      end
      if (cfg_we) begin
        unique case (lse_reg_t'(cfg_index))
          REG_MODE:    cfg.mode           <= cfg_data[0];
          REG_BPB:     cfg.bits_per_byte  <= cfg_data[3:0];
          REG_MSG_LEN: cfg.message_length <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_word.action   <= in_ch.action;
      s1_word.in_value <= in_ch.in_value;
      s1_word.in_last  <= in_ch.in_last;
    end
    if (advance && s1_valid) begin
      out_ch.out_value <= res.out_value;
      out_ch.out_kind  <= res.out_kind;
      out_ch.out_last  <= res.out_last;
      out_ch.status    <= res.status;
    end
  end

`ifndef NO_ASSERTIONS
  // The gearbox never holds more than two bytes of queued bits.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state.bit_count <= 5'd16)
    else $error("bit_count above 16");

  // In extract mode a byte is emitted as soon as 8 bits are gathered.
  a_extract_below_byte: assert property (@(posedge clk) disable iff (rst)
    cfg.mode != MODE_EMBED |-> state.bit_count < 5'd8)
    else $error("extract buffer holds a full byte");

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // Underrun is only reported on cover byte results.
  a_underrun_kind: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status == ST_UNDERRUN |-> out_ch.out_kind == KIND_COVER)
    else $error("underrun on a message byte result");
`endif

endmodule
